// ===== src/bdcp_pkg.sv =====
package bdcp_pkg;

    localparam int LEVEL_W = 8;
    localparam int POS_W   = 5;
    localparam int PROD_W  = 16;
    localparam int THR_W   = 13;
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] FULL_TOP = 8'd255;

    localparam logic [IDX_W-1:0] REG_RED_TOP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_TOP = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLUE_TOP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RED_POS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN_POS = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_POS  = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_top;
        logic [LEVEL_W-1:0] green_top;
        logic [LEVEL_W-1:0] blue_top;
        logic [POS_W-1:0]   red_pos;
        logic [POS_W-1:0]   green_pos;
        logic [POS_W-1:0]   blue_pos;
    } cfg_t;

    // load enables of the three pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctrl_t;

    // (2b+1)*255 for Bayer threshold b of each cell
    function automatic logic [THR_W-1:0] bayer_limit(input logic [3:0] cell_sel);
        logic [THR_W-1:0] lim;
        lim = '0;
        case (cell_sel)
            4'd0:    lim = 13'd255;
            4'd1:    lim = 13'd4335;
            4'd2:    lim = 13'd1275;
            4'd3:    lim = 13'd5355;
            4'd4:    lim = 13'd6375;
            4'd5:    lim = 13'd2295;
            4'd6:    lim = 13'd7395;
            4'd7:    lim = 13'd3315;
            4'd8:    lim = 13'd1785;
            4'd9:    lim = 13'd5865;
            4'd10:   lim = 13'd765;
            4'd11:   lim = 13'd4845;
            4'd12:   lim = 13'd7905;
            4'd13:   lim = 13'd3825;
            4'd14:   lim = 13'd6885;
            4'd15:   lim = 13'd2805;
            default: lim = 13'd255;
        endcase
        return lim;
    endfunction

endpackage

// ===== src/bdcp_cfg.sv =====
module bdcp_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bdcp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bdcp_pkg::LEVEL_W-1:0] cfg_data,
    output bdcp_pkg::cfg_t               cfg
);

    bdcp_pkg::cfg_t cfg_reg;
    bdcp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bdcp_pkg::REG_RED_TOP:   cfg_next.red_top   = cfg_data;
                bdcp_pkg::REG_GREEN_TOP: cfg_next.green_top = cfg_data;
                bdcp_pkg::REG_BLUE_TOP:  cfg_next.blue_top  = cfg_data;
                bdcp_pkg::REG_RED_POS:   cfg_next.red_pos   = cfg_data[bdcp_pkg::POS_W-1:0];
                bdcp_pkg::REG_GREEN_POS: cfg_next.green_pos = cfg_data[bdcp_pkg::POS_W-1:0];
                bdcp_pkg::REG_BLUE_POS:  cfg_next.blue_pos  = cfg_data[bdcp_pkg::POS_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_top   <= 8'd31;
            cfg_reg.green_top <= 8'd63;
            cfg_reg.blue_top  <= 8'd31;
            cfg_reg.red_pos   <= 5'd11;
            cfg_reg.green_pos <= 5'd5;
            cfg_reg.blue_pos  <= 5'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/bdcp_quant.sv =====
// one colour channel: multiply in stage 1, divide by 255 and dither in stage 2; a top of 255 passes the channel through
module bdcp_quant
(
    input  logic                         clk,
    input  bdcp_pkg::pipe_ctrl_t         ctrl,
    input  logic [bdcp_pkg::LEVEL_W-1:0] chan,
    input  logic [bdcp_pkg::LEVEL_W-1:0] top,
    input  logic [bdcp_pkg::THR_W-1:0]   limit,
    output logic [bdcp_pkg::LEVEL_W-1:0] level
);

    logic [bdcp_pkg::PROD_W-1:0]  prod_reg;
    logic [bdcp_pkg::PROD_W-1:0]  prod_next;
    logic [bdcp_pkg::LEVEL_W-1:0] chan_reg;
    logic                         bypass_reg;
    logic                         bypass_next;
    logic [bdcp_pkg::LEVEL_W-1:0] level_reg;
    logic [bdcp_pkg::LEVEL_W-1:0] level_next;

    logic [bdcp_pkg::PROD_W:0]    sum;
    logic [bdcp_pkg::LEVEL_W-1:0] quot;
    logic [bdcp_pkg::PROD_W-1:0]  rem_full;
    logic [bdcp_pkg::LEVEL_W-1:0] rem;
    logic                         bump;

    assign prod_next   = {{bdcp_pkg::LEVEL_W{1'b0}}, chan} * {{bdcp_pkg::LEVEL_W{1'b0}}, top};
    assign bypass_next = (top == bdcp_pkg::FULL_TOP);

    // exact floor(p/255) for p below 65280
    assign sum      = {1'b0, prod_reg} + 17'd1 + {9'd0, prod_reg[15:8]};
    assign quot     = sum[15:8];
    assign rem_full = prod_reg - {quot, 8'd0} + {8'd0, quot};
    assign rem      = rem_full[bdcp_pkg::LEVEL_W-1:0];
    assign bump     = ({rem, 5'd0} >= limit);

    always_comb
    begin
        if (bypass_reg)
            level_next = chan_reg;
        else
            level_next = quot + {7'd0, bump};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            prod_reg   <= prod_next;
            chan_reg   <= chan;
            bypass_reg <= bypass_next;
        end
        if (ctrl.ld2)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// ===== src/bdcp_pack.sv =====
module bdcp_pack
(
    input  logic                         clk,
    input  bdcp_pkg::pipe_ctrl_t         ctrl,
    input  bdcp_pkg::cfg_t               cfg,
    input  logic [bdcp_pkg::LEVEL_W-1:0] red_level,
    input  logic [bdcp_pkg::LEVEL_W-1:0] green_level,
    input  logic [bdcp_pkg::LEVEL_W-1:0] blue_level,
    output logic [bdcp_pkg::PIX_W-1:0]   packed_pixel,
    output logic                         full_range_mode
);

    logic [bdcp_pkg::PIX_W-1:0] pix_reg;
    logic [bdcp_pkg::PIX_W-1:0] pix_next;
    logic                       full_reg;
    logic                       full_next;
    logic [bdcp_pkg::PIX_W-1:0] pix_or;

    assign full_next = (cfg.red_top == bdcp_pkg::FULL_TOP)
                     && (cfg.green_top == bdcp_pkg::FULL_TOP)
                     && (cfg.blue_top == bdcp_pkg::FULL_TOP);

    assign pix_or = ({24'd0, red_level} << cfg.red_pos)
                  | ({24'd0, green_level} << cfg.green_pos)
                  | ({24'd0, blue_level} << cfg.blue_pos);

    assign pix_next = full_next ? pix_or : {16'd0, pix_or[15:0]};

    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            pix_reg  <= pix_next;
            full_reg <= full_next;
        end
    end

    assign packed_pixel    = pix_reg;
    assign full_range_mode = full_reg;

endmodule

// ===== src/bayer_dither_color_packer_core.sv =====
// Ordered-dither colour packer, 4x4 Bayer. Three-stage pipeline: multiply,
// divide by 255 with dither compare, then shift and pack. One colour is
// taken per clock unless a stall holds the pipeline; a result passes
// the multiply, divide and pack registers before it is presented, and
// a stall on the output holds every stage without losing a transfer.
// Configuration is written through cfg_valid/cfg_ready (always ready) and
// should only change while the pipeline is empty.
module bayer_dither_color_packer_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   red_in,
    input  logic [7:0]                   green_in,
    input  logic [7:0]                   blue_in,
    input  logic [3:0]                   cell_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  packed_pixel,
    output logic                         full_range_mode,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bdcp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bdcp_pkg::LEVEL_W-1:0] cfg_data
);

    bdcp_pkg::cfg_t       cfg;
    bdcp_pkg::pipe_ctrl_t ctrl;

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic [bdcp_pkg::THR_W-1:0]   limit_reg;
    logic [bdcp_pkg::LEVEL_W-1:0] red_level;
    logic [bdcp_pkg::LEVEL_W-1:0] green_level;
    logic [bdcp_pkg::LEVEL_W-1:0] blue_level;

    assign rdy3 = !v3_reg || !out_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall = !rdy1;

    assign ctrl.ld1 = rdy1 && in_valid;
    assign ctrl.ld2 = rdy2 && v1_reg;
    assign ctrl.ld3 = rdy3 && v2_reg;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
            limit_reg <= bdcp_pkg::bayer_limit(cell_index);
    end

    assign out_valid = v3_reg;

    bdcp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdcp_quant u_quant_red
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (red_in),
        .top   (cfg.red_top),
        .limit (limit_reg),
        .level (red_level)
    );

    bdcp_quant u_quant_green
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (green_in),
        .top   (cfg.green_top),
        .limit (limit_reg),
        .level (green_level)
    );

    bdcp_quant u_quant_blue
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .chan  (blue_in),
        .top   (cfg.blue_top),
        .limit (limit_reg),
        .level (blue_level)
    );

    bdcp_pack u_pack
    (
        .clk             (clk),
        .ctrl            (ctrl),
        .cfg             (cfg),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .packed_pixel    (packed_pixel),
        .full_range_mode (full_range_mode)
    );

endmodule
